// ===== design/aes_cbc_pkg.sv =====
`default_nettype none
package aes_cbc_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  col;
    logic [3:0]  row;
    logic [31:0] data;
  } rk_wr_t;

  localparam int unsigned RK_COLS = 4;
  localparam int unsigned RK_ROWS = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd7;

  localparam logic [7:0] GF_POLY = 8'h1B;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] REV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_fwd(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    mix_fwd = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] mix_inv(input logic [31:0] w);
    logic [7:0] a  [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      m2[k] = xt(a[k]);
      m4[k] = xt(m2[k]);
      m8[k] = xt(m4[k]);
      m9[k] = m8[k] ^ a[k];
      mb[k] = m8[k] ^ m2[k] ^ a[k];
      md[k] = m8[k] ^ m4[k] ^ a[k];
      me[k] = m8[k] ^ m4[k] ^ m2[k];
    end
    mix_inv = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
               m9[0] ^ me[1] ^ mb[2] ^ md[3],
               md[0] ^ m9[1] ^ me[2] ^ mb[3],
               mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = FWD_SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = last ? t[127-32*c -: 32] : mix_fwd(t[127-32*c -: 32]);
    end
    enc_round = m ^ rk;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = REV_SBOX[s[127-8*(4*c+r) -: 8]];
      end
    end
    t = t ^ rk;
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = last ? t[127-32*c -: 32] : mix_inv(t[127-32*c -: 32]);
    end
    dec_round = m;
  endfunction

endpackage
`default_nettype wire

// ===== design/aes_cbc_ram.sv =====
`default_nettype none
module aes_cbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 15
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/aes_cbc_kexp.sv =====
`default_nettype none
module aes_cbc_kexp
  import aes_cbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [1:0]   ks,
  input  wire logic [255:0] key,
  output logic              done,
  output rk_wr_t            wr
);
  logic        active_r, active_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [2:0]  m_r, m_nxt;
  logic [7:0]  rc_r, rc_nxt;
  logic [31:0] win_r [8];
  logic [3:0]  nk;
  logic [5:0]  last_i;
  logic [31:0] prev, t, word;

  always_comb begin
    unique case (ks)
      2'd0:    begin nk = 4'd4; last_i = 6'd43; end
      2'd1:    begin nk = 4'd6; last_i = 6'd51; end
      default: begin nk = 4'd8; last_i = 6'd59; end
    endcase
    prev   = win_r[nk[2:0] - 3'd1];
    t      = win_r[0];
    rc_nxt = rc_r;
    if (m_r == 3'd0) begin
      t      = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'h0};
      rc_nxt = xt(rc_r);
    end else if (nk == 4'd8 && m_r == 3'd4) begin
      t = sub_word(win_r[0]);
    end
    if (i_r < {2'b00, nk}) begin
      word   = key[255 - 32*i_r[2:0] -: 32];
      rc_nxt = rc_r;
    end else begin
      word = prev ^ t;
    end
    m_nxt      = (m_r == nk[2:0] - 3'd1) ? 3'd0 : m_r + 3'd1;
    i_nxt      = i_r + 6'd1;
    active_nxt = active_r && (i_r != last_i);
    if (start) begin
      active_nxt = 1'b1;
      i_nxt      = 6'd0;
      m_nxt      = 3'd0;
      rc_nxt     = 8'h01;
    end
  end

  assign wr.we   = active_r;
  assign wr.col  = i_r[1:0];
  assign wr.row  = i_r[5:2];
  assign wr.data = word;
  assign done    = active_r && (i_r == last_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    i_r  <= i_nxt;
    m_r  <= m_nxt;
    rc_r <= rc_nxt;
    if (active_r) begin
      win_r[0] <= word;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/aes_cbc_block_cipher_top.sv =====
`default_nettype none
// AES-CBC block cipher, one 128-bit block per item, 128/192/256-bit keys.
// A single round unit runs one AES round per cycle against the round-key store.
// The first block after reset or after a write to key_size or a key word first
// waits while the key is expanded, one word per cycle.
// The input is not ready while a block is in flight; the result sits in an
// output register. Write configuration only while the block is idle; a write to
// either IV register reloads the chaining value.
module aes_cbc_block_cipher_top
  import aes_cbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_KEY0, S_ADD0, S_ROUND, S_OUT} st_t;

  st_t          st_r;
  logic [1:0]   key_size_r;
  logic         dir_r;
  logic [63:0]  key_r [4];
  logic [63:0]  iv_high_r, iv_low_r;
  logic [127:0] chain_r, blk_r, s_r;
  logic         keys_ok_r, last_r, out_valid_r;
  logic [3:0]   rnd_r;
  out_item_t    out_r;
  logic [1:0]   ks;
  logic [3:0]   nr;
  logic [127:0] rk;
  logic [31:0]  rk_col [RK_COLS];
  logic         kx_start, kx_done;
  rk_wr_t       kx_wr;
  logic         in_acc, out_free;

  assign ks       = (key_size_r == 2'd3) ? 2'd2 : key_size_r;
  assign nr       = 4'd10 + {1'b0, ks, 1'b0};
  assign in_ready = (st_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign kx_start = in_acc && !keys_ok_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rk        = {rk_col[0], rk_col[1], rk_col[2], rk_col[3]};

  aes_cbc_kexp u_kexp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kx_start),
    .ks    (ks),
    .key   ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .done  (kx_done),
    .wr    (kx_wr)
  );

  for (genvar c = 0; c < RK_COLS; c++) begin : g_rk
    aes_cbc_ram #(.WIDTH(32), .DEPTH(RK_ROWS)) u_ram (
      .clk   (clk),
      .we    (kx_wr.we && kx_wr.col == 2'(c)),
      .waddr (kx_wr.row),
      .wdata (kx_wr.data),
      .raddr (rnd_r),
      .rdata (rk_col[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      key_size_r  <= 2'd0;
      dir_r       <= 1'b0;
      key_r       <= '{default: 64'h0};
      iv_high_r   <= 64'h0;
      iv_low_r    <= 64'h0;
      chain_r     <= 128'h0;
      keys_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_r <= dir_r ? (rnd_r == 4'd0) : (rnd_r == nr);
      if (out_valid_r && out_ready && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_SIZE: begin
            key_size_r <= cfg_data[1:0];
            keys_ok_r  <= 1'b0;
          end
          REG_DIRECTION: dir_r <= cfg_data[0];
          REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
            key_r[cfg_index[1:0] - 2'd2] <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          REG_IV_HIGH: begin
            iv_high_r <= cfg_data;
            chain_r   <= {cfg_data, iv_low_r};
          end
          REG_IV_LOW: begin
            iv_low_r <= cfg_data;
            chain_r  <= {iv_high_r, cfg_data};
          end
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            blk_r <= in_data;
            s_r   <= dir_r ? in_data : in_data ^ chain_r;
            rnd_r <= dir_r ? nr : 4'd0;
            st_r  <= keys_ok_r ? S_KEY0 : S_EXPAND;
          end
        end
        S_EXPAND: begin
          if (kx_done) begin
            keys_ok_r <= 1'b1;
            st_r      <= S_KEY0;
          end
        end
        S_KEY0: begin
          rnd_r <= dir_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
          st_r  <= S_ADD0;
        end
        S_ADD0: begin
          s_r   <= s_r ^ rk;
          rnd_r <= dir_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
          st_r  <= S_ROUND;
        end
        S_ROUND: begin
          if (dir_r) begin
            s_r <= dec_round(s_r, rk, last_r) ^ (last_r ? chain_r : 128'h0);
          end else begin
            s_r <= enc_round(s_r, rk, last_r);
          end
          rnd_r <= dir_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
          if (last_r) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_r       <= s_r;
            out_valid_r <= 1'b1;
            chain_r     <= dir_r ? blk_r : s_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sim/aes_cbc_block_cipher_top_test.sv =====
`timescale 1ns / 1ps
module aes_cbc_block_cipher_top_test;
  import aes_cbc_pkg::*;

  localparam int RANDOM_BLOCKS = 1330;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        known;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vector_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  logic [1:0] keylen_q;
  logic decrypt_q;
  logic [63:0] key_q [4];
  logic [63:0] iv_hi_q, iv_lo_q;
  logic [127:0] chain_q;
  logic [31:0] sched_q [60];
  bit sched_ok;

  out_item_t pending_q[$];
  int mismatches;
  int checked;
  int sent;

  aes_cbc_block_cipher_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [7:0] gdouble(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gprod(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gdouble(a);
    end
    return r;
  endfunction

  function automatic int round_count();
    return (keylen_q >= 2) ? 14 : 10 + 2 * keylen_q;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  task automatic build_schedule();
    int nr, nk;
    logic [31:0] t;
    logic [7:0] rc;
    nr = round_count();
    nk = nr - 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched_q[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = sched_q[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gdouble(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched_q[i] = sched_q[i - nk] ^ t;
    end
    sched_ok = 1;
  endtask

  function automatic void add_round_key(ref logic [7:0] s [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[4*c+r] ^= sched_q[4*rnd+c][31-8*r -: 8];
  endfunction

  function automatic void shift_bytes(ref logic [7:0] s [16], input bit inv);
    logic [7:0] t [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[4*((c+r)%4)+r] = s[4*c+r];
        else t[4*c+r] = s[4*((c+r)%4)+r];
    s = t;
  endfunction

  function automatic void mix_cols(ref logic [7:0] s [16], input bit inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    if (inv) m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
      for (int r = 0; r < 4; r++)
        s[4*c+r] = gprod(m[(4-r)%4], a[0]) ^ gprod(m[(5-r)%4], a[1]) ^
                   gprod(m[(6-r)%4], a[2]) ^ gprod(m[(7-r)%4], a[3]);
    end
  endfunction

  function automatic logic [127:0] cipher_block(logic [127:0] blk, bit inv);
    logic [7:0] s [16];
    int nr;
    nr = round_count();
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (!inv) begin
      add_round_key(s, 0);
      for (int i = 1; i <= nr; i++) begin
        for (int k = 0; k < 16; k++) s[k] = FWD_SBOX[s[k]];
        shift_bytes(s, 0);
        if (i != nr) mix_cols(s, 0);
        add_round_key(s, i);
      end
    end else begin
      add_round_key(s, nr);
      for (int i = nr - 1; i >= 0; i--) begin
        shift_bytes(s, 1);
        for (int k = 0; k < 16; k++) s[k] = REV_SBOX[s[k]];
        add_round_key(s, i);
        if (i != 0) mix_cols(s, 1);
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    return blk;
  endfunction

  task automatic predict_block(in_item_t item);
    logic [127:0] x, y;
    out_item_t o;
    if (!sched_ok) build_schedule();
    x = {item.block_high, item.block_low};
    if (decrypt_q) begin
      y = cipher_block(x, 1) ^ chain_q;
      chain_q = x;
    end else begin
      y = cipher_block(x ^ chain_q, 0);
      chain_q = y;
    end
    o.result_high = y[127:64];
    o.result_low = y[63:0];
    pending_q.push_back(o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_SIZE: begin
        keylen_q = val[1:0];
        sched_ok = 0;
      end
      REG_DIRECTION: decrypt_q = val[0];
      REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
        key_q[idx - REG_KEY_WORD0] = val;
        sched_ok = 0;
      end
      REG_IV_HIGH, REG_IV_LOW: begin
        if (idx == REG_IV_HIGH) iv_hi_q = val;
        else iv_lo_q = val;
        chain_q = {iv_hi_q, iv_lo_q};
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    in_item_t item;
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    repeat (gap + 1) @(negedge clk);
    item.block_high = hi;
    item.block_low = lo;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_block(item);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        if (out_data.result_high !== pending_q[0].result_high ||
            out_data.result_low !== pending_q[0].result_low) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h, got %h %h", pending_q[0].result_high,
                     pending_q[0].result_low, out_data.result_high, out_data.result_low);
        end
        void'(pending_q.pop_front());
        checked++;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 70) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40))
          @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #60ms;
    $display("aes_cbc_block_cipher_top_test failed");
    $finish;
  end

  vector_row_t vectors [] = '{
    '{64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
    '{64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0, 64'h0, 64'h0}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_SIZE;
    cfg_data = '0;
    mismatches = 0;
    checked = 0;
    sent = 0;
    keylen_q = 0;
    decrypt_q = 0;
    key_q = '{default: 64'h0};
    iv_hi_q = 0;
    iv_lo_q = 0;
    chain_q = 0;
    sched_ok = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].known) begin
        send_block(vectors[i].hi, vectors[i].lo);
        drain();
        if (checked == 1 && (vectors[i].exp_hi !== {chain_q[127:64]} ||
                             vectors[i].exp_lo !== chain_q[63:0])) begin
          mismatches++;
          $display("zero-key vector predicted %h", chain_q);
        end
      end else begin
        send_block(vectors[i].hi, vectors[i].lo);
      end
    end
    drain();

    for (int ks = 0; ks < 4; ks++) begin
      for (int d = 0; d < 2; d++) begin
        write_reg(REG_KEY_SIZE, 64'(ks));
        write_reg(REG_DIRECTION, 64'(d));
        for (int w = 0; w < 4; w++)
          write_reg(REG_KEY_WORD0 + CFG_IDX_W'(w),
                    (ks == 0 && d == 1) ? 64'hFFFFFFFFFFFFFFFF : rand64());
        write_reg(REG_IV_HIGH, d ? 64'h0 : rand64());
        write_reg(REG_IV_LOW, d ? 64'hFFFFFFFFFFFFFFFF : rand64());
        send_block(64'h0, 64'hFFFFFFFFFFFFFFFF);
        send_block(rand64(), rand64());
        drain();
      end
    end
    write_reg(REG_DIRECTION, 64'd1);
    send_block(rand64(), rand64());
    drain();

    while (sent < RANDOM_BLOCKS + 20) begin
      if ($urandom_range(0, 99) < 3) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_reg(REG_KEY_SIZE, 64'($urandom_range(0, 3)));
          1: write_reg(REG_DIRECTION, 64'($urandom_range(0, 1)));
          2: write_reg(REG_KEY_WORD0 + CFG_IDX_W'($urandom_range(0, 3)), rand64());
          default: write_reg($urandom_range(0, 1) ? REG_IV_HIGH : REG_IV_LOW, rand64());
        endcase
      end
      send_block(rand64(), rand64());
    end
    drain();

    $display("covered %0d blocks over all key sizes and both directions, %0d results checked",
             sent, checked);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("aes_cbc_block_cipher_top_test passed");
    else
      $display("aes_cbc_block_cipher_top_test failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/aes_cbc_pkg.sv
design/aes_cbc_ram.sv
design/aes_cbc_kexp.sv
design/aes_cbc_block_cipher_top.sv
sim/aes_cbc_block_cipher_top_test.sv
